// File: sv/qte_pkg.sv
`default_nettype none

package qte_pkg;

   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH_DEF     = 16;
   localparam int CORDIC_STAGES_DEF   = 16;

   // Components are brought below 2^24 in magnitude before the products.
   localparam int RED_MAG_W = 24;
   localparam int RED_W     = RED_MAG_W + 1;
   localparam int PROD_W    = 2 * RED_W;
   localparam int TERM_W    = PROD_W + 3;
   // The squared length is scaled into [2^28, 2^30).
   localparam int L_LO      = 28;
   localparam int L_HI      = 30;
   localparam int SCL_W     = L_HI;
   localparam int SV_W      = SCL_W + 2;
   localparam int SQ_W      = 2 * SCL_W;
   localparam int ISQ_W     = SQ_W + 1;
   localparam int ISQ_STEPS = SCL_W;
   localparam int CX_W      = SV_W + 2;
   localparam int TURN_W    = 32;

   localparam logic [TURN_W-1:0] HALF_TURN = {1'b1, {(TURN_W-1){1'b0}}};

   localparam int T_A = 0;
   localparam int T_B = 1;
   localparam int T_N = 2;
   localparam int T_C = 3;
   localparam int T_D = 4;

   localparam int LN_ROLL  = 0;
   localparam int LN_PITCH = 1;
   localparam int LN_YAW   = 2;

   typedef struct packed {
      logic signed [RED_W-1:0] x;
      logic signed [RED_W-1:0] y;
      logic signed [RED_W-1:0] z;
      logic signed [RED_W-1:0] w;
      logic                    zero;
   } s0_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] xx;
      logic signed [PROD_W-1:0] yy;
      logic signed [PROD_W-1:0] zz;
      logic signed [PROD_W-1:0] ww;
      logic signed [PROD_W-1:0] wx;
      logic signed [PROD_W-1:0] yz;
      logic signed [PROD_W-1:0] wy;
      logic signed [PROD_W-1:0] zx;
      logic signed [PROD_W-1:0] wz;
      logic signed [PROD_W-1:0] xy;
      logic                     zero;
   } s1_type;

   typedef struct packed {
      logic signed [TERM_W-1:0] l;
      logic signed [TERM_W-1:0] a;
      logic signed [TERM_W-1:0] b;
      logic signed [TERM_W-1:0] n;
      logic signed [TERM_W-1:0] c;
      logic signed [TERM_W-1:0] d;
      logic                     zero;
   } s2_type;

   typedef struct packed {
      logic [TERM_W-1:0]      lmag;
      logic [4:0][TERM_W-1:0] tmag;
      logic [4:0]             tneg;
      logic [4:0]             lsh;
      logic [4:0]             rsh;
      logic                   clamp;
      logic                   zero;
   } s3_type;

   typedef struct packed {
      logic signed [SV_W-1:0] a;
      logic signed [SV_W-1:0] b;
      logic signed [SV_W-1:0] n;
      logic signed [SV_W-1:0] c;
      logic signed [SV_W-1:0] d;
      logic                   clamp;
      logic                   zero;
   } carry_type;

   typedef struct packed {
      carry_type        cy;
      logic [SCL_W-1:0] lp;
      logic [SCL_W-1:0] nm;
   } s4_type;

   typedef struct packed {
      carry_type       cy;
      logic [SQ_W-1:0] lsq;
      logic [SQ_W-1:0] nsq;
   } s5_type;

   typedef struct packed {
      carry_type       cy;
      logic [SQ_W-1:0] rad;
   } s6_type;

   typedef struct packed {
      carry_type        cy;
      logic [ISQ_W-1:0] v;
      logic [ISQ_W-1:0] r;
   } isq_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic [TURN_W-1:0]      z;
   } cordic_lane_type;

   typedef struct packed {
      cordic_lane_type [2:0] ln;
      logic                  clamp;
      logic                  npos;
      logic                  zero;
   } cor_type;

   // Arctangent of 2^-i, in units of 2^-32 turn.
   function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
      case (idx)
         5'd0:  atan_turn = 32'd536870912;
         5'd1:  atan_turn = 32'd316933406;
         5'd2:  atan_turn = 32'd167458907;
         5'd3:  atan_turn = 32'd85004756;
         5'd4:  atan_turn = 32'd42667331;
         5'd5:  atan_turn = 32'd21354465;
         5'd6:  atan_turn = 32'd10679838;
         5'd7:  atan_turn = 32'd5340245;
         5'd8:  atan_turn = 32'd2670163;
         5'd9:  atan_turn = 32'd1335087;
         5'd10: atan_turn = 32'd667544;
         5'd11: atan_turn = 32'd333772;
         5'd12: atan_turn = 32'd166886;
         5'd13: atan_turn = 32'd83443;
         5'd14: atan_turn = 32'd41722;
         5'd15: atan_turn = 32'd20861;
         5'd16: atan_turn = 32'd10430;
         5'd17: atan_turn = 32'd5215;
         5'd18: atan_turn = 32'd2608;
         5'd19: atan_turn = 32'd1304;
         5'd20: atan_turn = 32'd652;
         5'd21: atan_turn = 32'd326;
         5'd22: atan_turn = 32'd163;
         5'd23: atan_turn = 32'd81;
         5'd24: atan_turn = 32'd41;
         5'd25: atan_turn = 32'd20;
         5'd26: atan_turn = 32'd10;
         5'd27: atan_turn = 32'd5;
         5'd28: atan_turn = 32'd3;
         5'd29: atan_turn = 32'd1;
         5'd30: atan_turn = 32'd1;
         default: atan_turn = 32'd0;
      endcase
   endfunction

   // A vector in the left half plane is turned by a half turn first.
   function automatic cordic_lane_type cordic_pre(input logic signed [CX_W-1:0] y,
                                                  input logic signed [CX_W-1:0] x);
      cordic_lane_type o;
      if (x < 0) begin
         o.x = -x;
         o.y = -y;
         o.z = HALF_TURN;
      end else begin
         o.x = x;
         o.y = y;
         o.z = '0;
      end
      return o;
   endfunction

   // Once y reaches zero the lane holds, which matches stopping the iteration.
   function automatic cordic_lane_type cordic_step(input cordic_lane_type s,
                                                   input logic [4:0] idx);
      cordic_lane_type o;
      o = s;
      if (s.y > 0) begin
         o.x = s.x + (s.y >>> idx);
         o.y = s.y - (s.x >>> idx);
         o.z = s.z + atan_turn(idx);
      end else if (s.y < 0) begin
         o.x = s.x - (s.y >>> idx);
         o.y = s.y + (s.x >>> idx);
         o.z = s.z - atan_turn(idx);
      end
      return o;
   endfunction

endpackage

`default_nettype wire

// File: sv/quaternion_to_euler.sv
`default_nettype none

// Quaternion to roll, pitch and yaw. One quaternion word is taken per cycle while
// req_ready is high, and the angles come out in order, as signed binary angles
// (2^(ANGLE_WIDTH-1) is pi). The pipeline holds the products and scaling of the
// squared length (7 stages), a bit-per-stage integer square root for the pitch
// cosine (30 stages) and three CORDIC vectoring lanes that run side by side, one
// iteration per stage. A two-word output queue lets the pipeline keep moving while a
// result waits; ready drops only when both entries are full. An all-zero input
// yields zero angles with zero_input set; pitch is forced to a quarter turn with
// pitch_clamped set when the sine term reaches magnitude one.
module quaternion_to_euler #(
   parameter int COMPONENT_WIDTH = qte_pkg::COMPONENT_WIDTH_DEF,
   parameter int ANGLE_WIDTH     = qte_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ANGLE_WIDTH-1:0]     rsp_roll_angle,
   output logic signed [ANGLE_WIDTH-1:0]     rsp_pitch_angle,
   output logic signed [ANGLE_WIDTH-1:0]     rsp_yaw_angle,
   output logic                              rsp_pitch_clamped,
   output logic                              rsp_zero_input
);
   import qte_pkg::*;

   localparam int CW  = COMPONENT_WIDTH;
   localparam int AW  = ANGLE_WIDTH;
   localparam int NST = 8 + ISQ_STEPS + CORDIC_STAGES;
   localparam int SH  = TURN_W - AW;
   localparam logic [TURN_W:0]  ROUND_INC = ({{TURN_W{1'b0}}, 1'b1} << SH) >> 1;
   localparam logic [AW-1:0]    QUARTER   = {{(AW-1){1'b0}}, 1'b1} << (AW - 2);

   typedef struct packed {
      logic [AW-1:0] roll;
      logic [AW-1:0] pitch;
      logic [AW-1:0] yaw;
      logic          clamp;
      logic          zero;
   } rsp_type;

   function automatic logic [AW-1:0] to_angle(input logic [TURN_W-1:0] z);
      logic [TURN_W:0] t;
      t = {1'b0, z} + ROUND_INC;
      return t[TURN_W-1:SH];
   endfunction

   logic            en;
   logic [NST-1:0]  vld_ff;

   // Stage 0: magnitude reduction of wide components, zero detection.
   logic signed [CW-1:0]    comp [4];
   logic [CW-1:0]           mag [4];
   logic [CW-1:0]           orm;
   logic [3:0]              red;
   logic [31:0]             m32 [4];
   logic [RED_MAG_W-1:0]    rm [4];
   logic signed [RED_W-1:0] qr [4];
   s0_type                  s0_in, s0_ff;

   assign comp[0] = req_quat_x;
   assign comp[1] = req_quat_y;
   assign comp[2] = req_quat_z;
   assign comp[3] = req_quat_w;

   always_comb begin
      orm = '0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = comp[i][CW-1] ? CW'(-comp[i]) : CW'(comp[i]);
         orm    = orm | mag[i];
      end
      red = '0;
      for (int k = 0; k < CW; k++) begin
         if (k >= RED_MAG_W && orm[k]) begin
            red = 4'(k - (RED_MAG_W - 1));
         end
      end
      for (int i = 0; i < 4; i++) begin
         m32[i] = 32'(mag[i]) >> red;
         rm[i]  = m32[i][RED_MAG_W-1:0];
         qr[i]  = comp[i][CW-1] ? -$signed({1'b0, rm[i]}) : $signed({1'b0, rm[i]});
      end
      s0_in.zero = (orm == '0);
      s0_in.x    = qr[0];
      s0_in.y    = qr[1];
      s0_in.z    = qr[2];
      s0_in.w    = s0_in.zero ? RED_W'(1) : qr[3];
   end

   // Stage 1: all pairwise products.
   s1_type s1_in, s1_ff;

   always_comb begin
      s1_in.xx   = s0_ff.x * s0_ff.x;
      s1_in.yy   = s0_ff.y * s0_ff.y;
      s1_in.zz   = s0_ff.z * s0_ff.z;
      s1_in.ww   = s0_ff.w * s0_ff.w;
      s1_in.wx   = s0_ff.w * s0_ff.x;
      s1_in.yz   = s0_ff.y * s0_ff.z;
      s1_in.wy   = s0_ff.w * s0_ff.y;
      s1_in.zx   = s0_ff.z * s0_ff.x;
      s1_in.wz   = s0_ff.w * s0_ff.z;
      s1_in.xy   = s0_ff.x * s0_ff.y;
      s1_in.zero = s0_ff.zero;
   end

   // Stage 2: squared length and the five product terms, all exact.
   s2_type s2_in, s2_ff;

   always_comb begin
      s2_in.l = TERM_W'(s1_ff.xx) + TERM_W'(s1_ff.yy) + TERM_W'(s1_ff.zz)
              + TERM_W'(s1_ff.ww);
      s2_in.a = (TERM_W'(s1_ff.wx) + TERM_W'(s1_ff.yz)) <<< 1;
      s2_in.b = s2_in.l - ((TERM_W'(s1_ff.xx) + TERM_W'(s1_ff.yy)) <<< 1);
      s2_in.n = (TERM_W'(s1_ff.wy) - TERM_W'(s1_ff.zx)) <<< 1;
      s2_in.c = (TERM_W'(s1_ff.wz) + TERM_W'(s1_ff.xy)) <<< 1;
      s2_in.d = s2_in.l - ((TERM_W'(s1_ff.yy) + TERM_W'(s1_ff.zz)) <<< 1);
      s2_in.zero = s1_ff.zero;
   end

   // Stage 3: pole test, sign and magnitude split, scaling amount.
   s3_type                   s3_in, s3_ff;
   logic signed [TERM_W-1:0] terms [5];
   logic [5:0]               lmsb;

   assign terms[T_A] = s2_ff.a;
   assign terms[T_B] = s2_ff.b;
   assign terms[T_N] = s2_ff.n;
   assign terms[T_C] = s2_ff.c;
   assign terms[T_D] = s2_ff.d;

   always_comb begin
      for (int t = 0; t < 5; t++) begin
         s3_in.tneg[t] = terms[t] < 0;
         s3_in.tmag[t] = s3_in.tneg[t] ? TERM_W'(-terms[t]) : TERM_W'(terms[t]);
      end
      s3_in.lmag = TERM_W'(s2_ff.l);
      lmsb = '0;
      for (int k = 0; k < TERM_W; k++) begin
         if (s3_in.lmag[k]) begin
            lmsb = 6'(k);
         end
      end
      s3_in.lsh   = (lmsb < 6'(L_LO)) ? 5'(L_LO - int'(lmsb)) : 5'd0;
      s3_in.rsh   = (lmsb >= 6'(L_HI)) ? 5'(int'(lmsb) - (L_HI - 1)) : 5'd0;
      s3_in.clamp = s3_in.tmag[T_N] >= s3_in.lmag;
      s3_in.zero  = s2_ff.zero;
   end

   // Stage 4: common scaling shift of the length and the terms.
   s4_type                 s4_in, s4_ff;
   logic [TERM_W-1:0]      lsc;
   logic [TERM_W-1:0]      tsc [5];
   logic signed [SV_W-1:0] tsv [5];

   always_comb begin
      lsc = (s3_ff.lsh != '0) ? (s3_ff.lmag << s3_ff.lsh) : (s3_ff.lmag >> s3_ff.rsh);
      for (int t = 0; t < 5; t++) begin
         tsc[t] = (s3_ff.lsh != '0) ? (s3_ff.tmag[t] << s3_ff.lsh)
                                    : (s3_ff.tmag[t] >> s3_ff.rsh);
         tsv[t] = s3_ff.tneg[t] ? -$signed({2'b00, tsc[t][SCL_W-1:0]})
                                :  $signed({2'b00, tsc[t][SCL_W-1:0]});
      end
      s4_in.cy.a     = tsv[T_A];
      s4_in.cy.b     = tsv[T_B];
      s4_in.cy.n     = tsv[T_N];
      s4_in.cy.c     = tsv[T_C];
      s4_in.cy.d     = tsv[T_D];
      s4_in.cy.clamp = s3_ff.clamp;
      s4_in.cy.zero  = s3_ff.zero;
      s4_in.lp       = lsc[SCL_W-1:0];
      s4_in.nm       = tsc[T_N][SCL_W-1:0];
   end

   // Stage 5 and 6: cosine squared of pitch, scaled, as L'^2 - n'^2.
   s5_type s5_in, s5_ff;
   s6_type s6_in, s6_ff;

   always_comb begin
      s5_in.cy  = s4_ff.cy;
      s5_in.lsq = SQ_W'(s4_ff.lp) * SQ_W'(s4_ff.lp);
      s5_in.nsq = SQ_W'(s4_ff.nm) * SQ_W'(s4_ff.nm);
      s6_in.cy  = s5_ff.cy;
      s6_in.rad = s5_ff.lsq - s5_ff.nsq;
   end

   // Integer square root, one result bit per stage.
   isq_type isq_src [ISQ_STEPS];
   isq_type isq_in  [ISQ_STEPS];
   isq_type isq_ff  [ISQ_STEPS];

   for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
      localparam logic [ISQ_W-1:0] BIT = {{(ISQ_W-1){1'b0}}, 1'b1} << (SQ_W - 2 - 2 * j);
      logic [ISQ_W-1:0] trial;

      if (j == 0) begin : g_first
         always_comb begin
            isq_src[j].cy = s6_ff.cy;
            isq_src[j].v  = ISQ_W'(s6_ff.rad);
            isq_src[j].r  = '0;
         end
      end else begin : g_next
         assign isq_src[j] = isq_ff[j-1];
      end

      always_comb begin
         trial        = isq_src[j].r + BIT;
         isq_in[j].cy = isq_src[j].cy;
         if (isq_src[j].v >= trial) begin
            isq_in[j].v = isq_src[j].v - trial;
            isq_in[j].r = (isq_src[j].r >> 1) + BIT;
         end else begin
            isq_in[j].v = isq_src[j].v;
            isq_in[j].r = isq_src[j].r >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            isq_ff[j] <= isq_in[j];
         end
      end
   end

   // Half-turn pre-rotation of the three vectoring lanes.
   cor_type    pre_in, pre_ff;
   carry_type  fin_cy;
   logic [SCL_W-1:0] root;

   assign fin_cy = isq_ff[ISQ_STEPS-1].cy;
   assign root   = isq_ff[ISQ_STEPS-1].r[SCL_W-1:0];

   always_comb begin
      pre_in.ln[LN_ROLL]  = cordic_pre(CX_W'(fin_cy.a), CX_W'(fin_cy.b));
      pre_in.ln[LN_PITCH] = cordic_pre(CX_W'(fin_cy.n), $signed(CX_W'(root)));
      pre_in.ln[LN_YAW]   = cordic_pre(CX_W'(fin_cy.c), CX_W'(fin_cy.d));
      pre_in.clamp        = fin_cy.clamp;
      pre_in.npos         = fin_cy.n > 0;
      pre_in.zero         = fin_cy.zero;
   end

   cor_type cor_src [CORDIC_STAGES];
   cor_type cor_in  [CORDIC_STAGES];
   cor_type cor_ff  [CORDIC_STAGES];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      if (i == 0) begin : g_first
         assign cor_src[i] = pre_ff;
      end else begin : g_next
         assign cor_src[i] = cor_ff[i-1];
      end

      always_comb begin
         cor_in[i] = cor_src[i];
         for (int k = 0; k < 3; k++) begin
            cor_in[i].ln[k] = cordic_step(cor_src[i].ln[k], 5'(i));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cor_ff[i] <= cor_in[i];
         end
      end
   end

   // Final formatting into the output queue.
   cor_type cor_last;
   rsp_type push_word;

   assign cor_last = cor_ff[CORDIC_STAGES-1];

   always_comb begin
      push_word.roll  = to_angle(cor_last.ln[LN_ROLL].z);
      push_word.yaw   = to_angle(cor_last.ln[LN_YAW].z);
      push_word.clamp = cor_last.clamp;
      push_word.zero  = cor_last.zero;
      if (cor_last.clamp) begin
         push_word.pitch = cor_last.npos ? QUARTER : -QUARTER;
      end else begin
         push_word.pitch = to_angle(cor_last.ln[LN_PITCH].z);
      end
   end

   rsp_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   // The pipeline moves only while the queue has a free entry.
   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;
   assign push      = en && vld_ff[NST-1];
   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   assign rsp_roll_angle    = ent_ff[rd_ptr_ff].roll;
   assign rsp_pitch_angle   = ent_ff[rd_ptr_ff].pitch;
   assign rsp_yaw_angle     = ent_ff[rd_ptr_ff].yaw;
   assign rsp_pitch_clamped = ent_ff[rd_ptr_ff].clamp;
   assign rsp_zero_input    = ent_ff[rd_ptr_ff].zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[NST-2:0], req_valid};
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff  <= s0_in;
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         pre_ff <= pre_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// File: dv/tb_quaternion_to_euler.sv
`default_nettype none

typedef struct {
   logic signed [15:0] roll;
   logic signed [15:0] pitch;
   logic signed [15:0] yaw;
   logic               clamped;
   logic               zero;
} euler_type;

class euler_scoreboard;
   euler_type pending[$];
   int        errors;

   static function longint floor_shr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
   endfunction

   static function longint mag_shift(longint v, int lsh, int rsh);
      longint unsigned m;
      m = v < 0 ? -v : v;
      m = (m << lsh) >> rsh;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   static function logic [31:0] vector_angle(longint y, longint x);
      logic [31:0] acc;
      longint      nx;
      acc = '0;
      if (x == 0 && y == 0) return acc;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = qte_pkg::HALF_TURN;
      end
      for (int i = 0; i < qte_pkg::CORDIC_STAGES_DEF; i++) begin
         if (y == 0) break;
         if (y > 0) begin
            nx = x + floor_shr(y, i);
            y = y - floor_shr(x, i);
            acc += qte_pkg::atan_turn(5'(i));
         end else begin
            nx = x - floor_shr(y, i);
            y = y + floor_shr(x, i);
            acc -= qte_pkg::atan_turn(5'(i));
         end
         x = nx;
      end
      return acc;
   endfunction

   static function logic [15:0] to_angle(logic [31:0] acc);
      logic [32:0] v;
      v = {1'b0, acc} + 33'd32768;
      return v[31:16];
   endfunction

   static function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Components of 16 bits never need the wide reduction, so the terms are exact.
   function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
      euler_type       e;
      longint          x, y, z, w, a, b, n, c, d;
      longint unsigned len, nm;
      int              lsh, rsh;
      x = qx; y = qy; z = qz; w = qw;
      e.zero = (x == 0 && y == 0 && z == 0 && w == 0);
      if (e.zero) w = 1;
      len = x*x + y*y + z*z + w*w;
      a = 2*(w*x + y*z);
      b = longint'(len) - 2*(x*x + y*y);
      n = 2*(w*y - z*x);
      c = 2*(w*z + x*y);
      d = longint'(len) - 2*(y*y + z*z);
      nm = n < 0 ? -n : n;
      e.clamped = nm >= len;
      lsh = 0; rsh = 0;
      while ((len << lsh) < (64'd1 << 28)) lsh++;
      while ((len >> rsh) >= (64'd1 << 30)) rsh++;
      len = (len << lsh) >> rsh;
      a = mag_shift(a, lsh, rsh);
      b = mag_shift(b, lsh, rsh);
      n = mag_shift(n, lsh, rsh);
      c = mag_shift(c, lsh, rsh);
      d = mag_shift(d, lsh, rsh);
      e.roll = to_angle(vector_angle(a, b));
      if (e.clamped) begin
         e.pitch = n > 0 ? 16'sd16384 : -16'sd16384;
      end else begin
         nm = n < 0 ? -n : n;
         e.pitch = to_angle(vector_angle(n, longint'(root_floor(len*len - nm*nm))));
      end
      e.yaw = to_angle(vector_angle(c, d));
      pending.push_back(e);
   endfunction

   function void check_angles(euler_type got);
      euler_type e;
      if (pending.size() == 0) begin
         $error("result word with nothing expected");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.roll !== e.roll) begin
         $error("roll_angle: expected %0d, got %0d", e.roll, got.roll);
         errors++;
      end
      if (got.pitch !== e.pitch) begin
         $error("pitch_angle: expected %0d, got %0d", e.pitch, got.pitch);
         errors++;
      end
      if (got.yaw !== e.yaw) begin
         $error("yaw_angle: expected %0d, got %0d", e.yaw, got.yaw);
         errors++;
      end
      if (got.clamped !== e.clamped) begin
         $error("pitch_clamped: expected %0b, got %0b", e.clamped, got.clamped);
         errors++;
      end
      if (got.zero !== e.zero) begin
         $error("zero_input: expected %0b, got %0b", e.zero, got.zero);
         errors++;
      end
   endfunction
endclass

module tb_quaternion_to_euler;
   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_quat_x = 0, req_quat_y = 0, req_quat_z = 0, req_quat_w = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;
   logic rsp_pitch_clamped, rsp_zero_input;

   euler_scoreboard board = new();
   int  send_idle = 0;
   int  recv_idle = 0;
   bit  hold_off = 0;

   quaternion_to_euler DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_quat_x(req_quat_x), .req_quat_y(req_quat_y),
      .req_quat_z(req_quat_z), .req_quat_w(req_quat_w),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_roll_angle(rsp_roll_angle), .rsp_pitch_angle(rsp_pitch_angle),
      .rsp_yaw_angle(rsp_yaw_angle), .rsp_pitch_clamped(rsp_pitch_clamped),
      .rsp_zero_input(rsp_zero_input)
   );

   always #10 clock = ~clock;

   // Sender: presents one word and holds it until the block takes it.
   task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                            logic signed [15:0] qz, logic signed [15:0] qw);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_quat_x <= qx;
      req_quat_y <= qy;
      req_quat_z <= qz;
      req_quat_w <= qw;
      do @(posedge clock); while (!req_ready);
      board.note_quat(qx, qy, qz, qw);
      @(negedge clock);
   endtask

   task automatic send_random;
      logic signed [15:0] q[4];
      int pick;
      pick = $urandom_range(9);
      foreach (q[i]) q[i] = 16'($urandom);
      if (pick == 0) begin
         // Near a pole: w = y and z = -x, or w = -y and z = x, give a sine term of one.
         q[1] = q[3];
         q[2] = -q[0];
         if ($urandom_range(1)) begin
            q[1] = -q[3];
            q[2] = q[0];
         end
      end else if (pick == 1) begin
         foreach (q[i]) q[i] = 16'($signed(16'($urandom_range(15))) - 8);
      end else if (pick == 2) begin
         q[$urandom_range(3)] = 0;
         q[$urandom_range(3)] = 0;
      end
      send_quat(q[0], q[1], q[2], q[3]);
   endtask

   always @(negedge clock) begin
      if (reset || hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_angles('{rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle,
                              rsp_pitch_clamped, rsp_zero_input});
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_quat(0, 0, 0, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(-32768, -32768, -32768, -32768);
      send_quat(32767, 32767, 32767, 32767);
      send_quat(-32768, 0, 0, 0);
      send_quat(0, 32767, 0, 32767);
      send_quat(0, -32768, 0, 32767);
      send_quat(11585, 11585, 11585, 11585);
      send_quat(-11585, 11585, -11585, 11585);
      send_quat(0, 0, 0, -1);
      send_quat(1, 0, 0, 0);
      send_quat(0, 0, -1, 0);
      send_quat(16384, 0, 0, 16384);
      send_quat(0, 0, 16384, 16384);
      send_quat(32767, -32768, 32767, -32768);

      // Long stall on the result side while words keep coming.
      hold_off = 1;
      fork
         repeat (120) @(posedge clock);
         repeat (60) send_random();
      join_any
      hold_off = 0;
      wait fork;

      send_idle = 12; recv_idle = 69;
      repeat (110) send_random();
      send_idle = 69; recv_idle = 12;
      repeat (110) send_random();
      send_idle = 0; recv_idle = 0;
      repeat (110) send_random();
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

`default_nettype wire

// File: files.f
sv/qte_pkg.sv
sv/quaternion_to_euler.sv
dv/tb_quaternion_to_euler.sv
